// ===== sv/i2cm_pkg.sv =====
// ----------------------------------------------------------------------------
// i2cm_pkg
// Shared types and constants for the I2C master line engine.
// ----------------------------------------------------------------------------
`default_nettype none

package i2cm_pkg;

    localparam int unsigned EDGE_HOLD_TICKS_DEF = 4;
    localparam int unsigned BIT_PHASE_TICKS_DEF = 2;

    localparam int unsigned DLY_W     = 4;   // hold counters up to 15 ticks
    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned BCNT_W    = 4;
    localparam int unsigned OPCODE_W  = 3;

    localparam logic [BYTE_W-1:0] ACK_TIMEOUT_RST = 8'd250;
    localparam logic [BCNT_W-1:0] BITS_PER_BYTE   = 4'd8;

    typedef enum logic [OPCODE_W-1:0] {
        OP_START = 3'd0,
        OP_STOP  = 3'd1,
        OP_WRITE = 3'd2,
        OP_READ  = 3'd3,
        OP_WACK  = 3'd4
    } t_opcode;

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_ST_A,
        PH_ST_B,
        PH_SP_A,
        PH_SP_B,
        PH_W_DATA,
        PH_W_HIGH,
        PH_W_LOW,
        PH_R_LOW,
        PH_R_HIGH,
        PH_K_LOW,
        PH_K_HIGH,
        PH_A_REL,
        PH_A_RISE,
        PH_A_POLL
    } t_phase;

    typedef struct packed {
        logic                cmd_valid;
        logic [OPCODE_W-1:0] opcode;
        logic [BYTE_W-1:0]   write_byte;
        logic                send_ack;
        logic                sda_sample;
    } t_tick;

    typedef struct packed {
        logic              ack_missing;
        logic [BYTE_W-1:0] read_data;
        logic              done_res;
        logic              busy_res;
        logic              sda_drive;
        logic              sda_level;
        logic              scl_level;
    } t_result;

endpackage : i2cm_pkg

`default_nettype wire

// ===== sv/i2cm_core.sv =====
// ----------------------------------------------------------------------------
// i2cm_core
// Bus sequencer: holds the engine state and works out one tick per step.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cm_core
    import i2cm_pkg::*;
#(
    parameter int unsigned EDGE_HOLD_TICKS = EDGE_HOLD_TICKS_DEF,
    parameter int unsigned BIT_PHASE_TICKS = BIT_PHASE_TICKS_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_step,
    input  wire t_tick             i_tick,
    input  wire logic [BYTE_W-1:0] i_ack_timeout,
    output t_result                o_result
);

    localparam logic [DLY_W-1:0] EDGE_HOLD = DLY_W'(EDGE_HOLD_TICKS - 1);
    localparam logic [DLY_W-1:0] BIT_HOLD  = DLY_W'(BIT_PHASE_TICKS - 1);

    t_phase              r_phase,      n_phase;
    logic [BCNT_W-1:0]   r_bit_count,  n_bit_count;
    logic [BYTE_W-1:0]   r_shift,      n_shift;
    logic [DLY_W-1:0]    r_delay,      n_delay;
    logic [BYTE_W-1:0]   r_poll_count, n_poll_count;
    logic                r_scl,        n_scl;
    logic                r_sda,        n_sda;
    logic                r_drv,        n_drv;
    logic                r_ack_choice, n_ack_choice;
    logic [BYTE_W-1:0]   r_rx_byte,    n_rx_byte;
    logic                r_ack_miss,   n_ack_miss;

    logic                done;
    logic                do_poll;
    logic [BYTE_W-1:0]   poll_base;
    logic [BCNT_W-1:0]   bc_inc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_bit_count  <= '0;
            r_shift      <= '0;
            r_delay      <= '0;
            r_poll_count <= '0;
            r_scl        <= 1'b1;
            r_sda        <= 1'b1;
            r_drv        <= 1'b1;
            r_ack_choice <= 1'b0;
            r_rx_byte    <= '0;
            r_ack_miss   <= 1'b0;
        end else if (i_step) begin
            r_phase      <= n_phase;
            r_bit_count  <= n_bit_count;
            r_shift      <= n_shift;
            r_delay      <= n_delay;
            r_poll_count <= n_poll_count;
            r_scl        <= n_scl;
            r_sda        <= n_sda;
            r_drv        <= n_drv;
            r_ack_choice <= n_ack_choice;
            r_rx_byte    <= n_rx_byte;
            r_ack_miss   <= n_ack_miss;
        end
    end

    always_comb begin
        n_phase      = r_phase;
        n_bit_count  = r_bit_count;
        n_shift      = r_shift;
        n_delay      = r_delay;
        n_poll_count = r_poll_count;
        n_scl        = r_scl;
        n_sda        = r_sda;
        n_drv        = r_drv;
        n_ack_choice = r_ack_choice;
        n_rx_byte    = r_rx_byte;
        n_ack_miss   = r_ack_miss;
        done         = 1'b0;
        do_poll      = 1'b0;
        poll_base    = r_poll_count;
        bc_inc       = r_bit_count + 1'b1;

        if (r_phase == PH_IDLE) begin
            if (i_tick.cmd_valid) begin
                case (t_opcode'(i_tick.opcode))
                    OP_START: begin
                        n_drv   = 1'b1;
                        n_sda   = 1'b1;
                        n_scl   = 1'b1;
                        n_phase = PH_ST_A;
                        n_delay = EDGE_HOLD;
                    end
                    OP_STOP: begin
                        n_drv   = 1'b1;
                        n_scl   = 1'b0;
                        n_sda   = 1'b0;
                        n_phase = PH_SP_A;
                        n_delay = EDGE_HOLD;
                    end
                    OP_WRITE: begin
                        n_drv       = 1'b1;
                        n_scl       = 1'b0;
                        n_bit_count = '0;
                        n_sda       = i_tick.write_byte[BYTE_W-1];
                        n_shift     = {i_tick.write_byte[BYTE_W-2:0], 1'b0};
                        n_phase     = PH_W_DATA;
                        n_delay     = BIT_HOLD;
                    end
                    OP_READ: begin
                        n_drv        = 1'b0;
                        n_scl        = 1'b0;
                        n_ack_choice = i_tick.send_ack;
                        n_shift      = '0;
                        n_bit_count  = '0;
                        n_phase      = PH_R_LOW;
                        n_delay      = BIT_HOLD;
                    end
                    OP_WACK: begin
                        n_drv   = 1'b0;
                        n_sda   = 1'b1;
                        n_phase = PH_A_REL;
                        n_delay = '0;
                    end
                    default: begin
                        n_phase = PH_IDLE;
                    end
                endcase
            end
        end else if (r_phase == PH_A_POLL) begin
            do_poll = 1'b1;
        end else if (r_delay != '0) begin
            n_delay = r_delay - 1'b1;
        end else begin
            case (r_phase)
                PH_ST_A: begin
                    n_sda   = 1'b0;
                    n_phase = PH_ST_B;
                    n_delay = EDGE_HOLD;
                end
                PH_ST_B: begin
                    n_scl   = 1'b0;
                    n_phase = PH_IDLE;
                    done    = 1'b1;
                end
                PH_SP_A: begin
                    n_scl   = 1'b1;
                    n_sda   = 1'b1;
                    n_phase = PH_SP_B;
                    n_delay = EDGE_HOLD;
                end
                PH_SP_B: begin
                    n_phase = PH_IDLE;
                    done    = 1'b1;
                end
                PH_W_DATA: begin
                    n_scl   = 1'b1;
                    n_phase = PH_W_HIGH;
                    n_delay = BIT_HOLD;
                end
                PH_W_HIGH: begin
                    n_scl   = 1'b0;
                    n_phase = PH_W_LOW;
                    n_delay = BIT_HOLD;
                end
                PH_W_LOW: begin
                    n_bit_count = bc_inc;
                    if (bc_inc >= BITS_PER_BYTE) begin
                        n_phase = PH_IDLE;
                        done    = 1'b1;
                    end else begin
                        n_sda   = r_shift[BYTE_W-1];
                        n_shift = {r_shift[BYTE_W-2:0], 1'b0};
                        n_phase = PH_W_DATA;
                        n_delay = BIT_HOLD;
                    end
                end
                PH_R_LOW: begin
                    n_scl       = 1'b1;
                    n_shift     = {r_shift[BYTE_W-2:0], i_tick.sda_sample};
                    n_bit_count = bc_inc;
                    n_phase     = PH_R_HIGH;
                    n_delay     = '0;
                end
                PH_R_HIGH: begin
                    n_scl = 1'b0;
                    if (r_bit_count >= BITS_PER_BYTE) begin
                        n_rx_byte = r_shift;
                        n_drv     = 1'b1;
                        n_sda     = ~r_ack_choice;
                        n_phase   = PH_K_LOW;
                    end else begin
                        n_phase   = PH_R_LOW;
                    end
                    n_delay = BIT_HOLD;
                end
                PH_K_LOW: begin
                    n_scl   = 1'b1;
                    n_phase = PH_K_HIGH;
                    n_delay = BIT_HOLD;
                end
                PH_K_HIGH: begin
                    n_scl   = 1'b0;
                    n_phase = PH_IDLE;
                    done    = 1'b1;
                end
                PH_A_REL: begin
                    n_scl   = 1'b1;
                    n_phase = PH_A_RISE;
                    n_delay = '0;
                end
                PH_A_RISE: begin
                    // first poll happens on the tick after the rising edge
                    do_poll   = 1'b1;
                    poll_base = '0;
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase
        end

        if (do_poll) begin
            if (!i_tick.sda_sample) begin
                n_scl      = 1'b0;
                n_ack_miss = 1'b0;
                n_phase    = PH_IDLE;
                done       = 1'b1;
            end else if (poll_base == i_ack_timeout) begin
                // no acknowledge: give up and release the bus with a stop
                n_ack_miss   = 1'b1;
                n_scl        = 1'b0;
                n_sda        = 1'b0;
                n_drv        = 1'b1;
                n_poll_count = poll_base;
                n_phase      = PH_SP_A;
                n_delay      = EDGE_HOLD;
            end else begin
                n_poll_count = poll_base + 1'b1;
                n_phase      = PH_A_POLL;
            end
        end
    end

    always_comb begin
        o_result.scl_level   = n_scl;
        o_result.sda_level   = n_sda;
        o_result.sda_drive   = n_drv;
        o_result.busy_res    = (n_phase != PH_IDLE);
        o_result.done_res    = done;
        o_result.read_data   = n_rx_byte;
        o_result.ack_missing = n_ack_miss;
    end

endmodule : i2cm_core

`default_nettype wire

// ===== sv/i2c_master_bit_engine.sv =====
// path: a tick's result reaches the master side through the input register and
//   then the result register, which takes it once the result side has room
// throughput: one tick per cycle, the input and result registers both advance
//   in the same cycle while the result side takes data
// reset: synchronous active-low; bus lines come up released high and driven,
//   engine idle, ack timeout 250
// ----------------------------------------------------------------------------
// i2c_master_bit_engine
// I2C master line engine: one tick in, one set of bus levels and flags out.
// ----------------------------------------------------------------------------
`default_nettype none

module i2c_master_bit_engine
    import i2cm_pkg::*;
#(
    parameter int unsigned EDGE_HOLD_TICKS = EDGE_HOLD_TICKS_DEF,
    parameter int unsigned BIT_PHASE_TICKS = BIT_PHASE_TICKS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // configuration: ack_timeout
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [7:0]  i_cfg_data,
    // tick input
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,  // write_byte[7:0], send_ack, sda_sample, zero pad
    input  wire logic [3:0]  s_axis_tuser,  // cmd_valid, opcode[2:0]
    // result output
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata   // scl_level, sda_level, sda_drive, busy_res,
                                            // done_res, read_data[7:0], ack_missing, zero pad
);

    logic [BYTE_W-1:0] r_ack_timeout;
    logic              r_in_valid;
    t_tick             r_in;
    logic              r_out_valid;
    t_result           r_out;
    t_result           result;
    logic              step;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ack_timeout <= ACK_TIMEOUT_RST;
        end else if (i_cfg_valid) begin
            r_ack_timeout <= i_cfg_data;
        end
    end

    assign step          = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in.cmd_valid  <= s_axis_tuser[0];
            r_in.opcode     <= s_axis_tuser[3:1];
            r_in.write_byte <= s_axis_tdata[7:0];
            r_in.send_ack   <= s_axis_tdata[8];
            r_in.sda_sample <= s_axis_tdata[9];
        end
    end

    i2cm_core #(
        .EDGE_HOLD_TICKS (EDGE_HOLD_TICKS),
        .BIT_PHASE_TICKS (BIT_PHASE_TICKS)
    ) u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (step),
        .i_tick        (r_in),
        .i_ack_timeout (r_ack_timeout),
        .o_result      (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (!r_out_valid || m_axis_tready) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out <= result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {2'b00,
                            r_out.ack_missing,
                            r_out.read_data,
                            r_out.done_res,
                            r_out.busy_res,
                            r_out.sda_drive,
                            r_out.sda_level,
                            r_out.scl_level};

endmodule : i2c_master_bit_engine

`default_nettype wire

// ===== sv/i2cm_checker.sv =====
// ----------------------------------------------------------------------------
// i2cm_checker
// Port-level checks on the I2C master line engine, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cm_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_cfg_valid,
    input wire logic        o_cfg_ready,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [15:0] m_axis_tdata
);

    // a completed command never reports itself as still running
    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !(m_axis_tdata[4] && m_axis_tdata[3]))
        else $error("done and busy both set");

    // with the result side empty the input side must take a transaction
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty result register");

    // a stalled result holds its contents
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("result changed while stalled");

    // a configuration write always completes in its cycle
    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid |-> o_cfg_ready)
        else $error("configuration write not taken");

endmodule : i2cm_checker

bind i2c_master_bit_engine i2cm_checker u_i2cm_checker (.*);

`default_nettype wire

// ===== tb/sv/i2c_master_bit_engine_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// i2c_master_bit_engine_tb
// Self-checking bench for the I2C master line engine. A directed command table
// is played first: idle ticks, the unused opcodes, start, stop, byte writes,
// reads with ACK and NACK, ACK waits that see the slave answer and one that
// runs into the timeout. Random command streams follow under several ACK
// timeout settings. Each accepted tick runs through a local model of the engine;
// results are compared field by field against it or, for typed rows, a fixed value.
// ----------------------------------------------------------------------------

module i2c_master_bit_engine_tb;
    import i2cm_pkg::*;

    localparam logic [OPCODE_W-1:0] OP_RSVD5 = 3'd5;
    localparam logic [OPCODE_W-1:0] OP_RSVD6 = 3'd6;
    localparam logic [OPCODE_W-1:0] OP_RSVD7 = 3'd7;

    localparam int unsigned IDLE_LIMIT    = 1000;
    localparam int unsigned PHASE_TICKS   = 180;
    localparam int unsigned ACK_NEVER     = 300;   // more high polls than any timeout allows

    localparam t_result IDLE_LINES = '{ack_missing: 1'b0, read_data: 8'h00, done_res: 1'b0,
                                       busy_res: 1'b0, sda_drive: 1'b1, sda_level: 1'b1,
                                       scl_level: 1'b1};
    localparam t_result START_LINES = '{ack_missing: 1'b0, read_data: 8'h00, done_res: 1'b0,
                                        busy_res: 1'b1, sda_drive: 1'b1, sda_level: 1'b1,
                                        scl_level: 1'b1};

    typedef struct packed {
        logic                cmd;
        logic [OPCODE_W-1:0] op;
        logic [7:0]          wbyte;
        logic                sack;
        logic                sda_fill;
        logic [8:0]          ack_highs;
        logic                typed;
        t_result             want;
    } t_cmd_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [7:0]  i_cfg_data = 8'h00;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = 16'h0000;
    logic [3:0]  s_axis_tuser = 4'h0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;

    i2c_master_bit_engine dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // engine model state
    t_phase      eng_phase;
    logic [3:0]  eng_bits;
    logic [7:0]  eng_shift;
    logic [3:0]  eng_hold;
    logic [7:0]  eng_polls;
    logic        eng_scl, eng_sda, eng_drv;
    logic        eng_ack_choice;
    logic [7:0]  eng_rx;
    logic        eng_miss;
    logic [7:0]  eng_timeout;

    t_result     bus_levels_q[$];
    t_cmd_row    cmd_table[$];
    int unsigned fail_count = 0;
    int unsigned idle_cycles = 0;

    // stimulus shaping
    int unsigned ack_highs_left = 0;
    logic        read_fill = 1'b0;
    logic        read_rand = 1'b1;
    logic        force_timeout = 1'b0;
    logic        tx_burst = 1'b0;
    logic        rx_burst = 1'b0;
    int unsigned rx_stall_left = 0;

    function automatic int unsigned pick_gap();
        if ($urandom_range(0, 99) < 85)
            return $urandom_range(1, 3);
        return $urandom_range(5, 20);
    endfunction

    task automatic enter_phase(input t_phase ph, input int unsigned n);
        eng_phase = ph;
        eng_hold  = 4'((n - 1) & 32'hF);
    endtask

    task automatic poll_ack(input logic sample, output logic fin);
        fin = 1'b0;
        if (!sample) begin
            eng_scl   = 1'b0;
            eng_miss  = 1'b0;
            eng_phase = PH_IDLE;
            fin       = 1'b1;
        end else if (eng_polls == eng_timeout) begin
            // slave never answered: flag it and free the bus with a stop
            eng_miss = 1'b1;
            eng_scl  = 1'b0;
            eng_sda  = 1'b0;
            eng_drv  = 1'b1;
            enter_phase(PH_SP_A, EDGE_HOLD_TICKS_DEF);
        end else begin
            eng_polls = eng_polls + 8'd1;
        end
    endtask

    task automatic load_write_bit();
        eng_sda   = eng_shift[7];
        eng_shift = {eng_shift[6:0], 1'b0};
        enter_phase(PH_W_DATA, BIT_PHASE_TICKS_DEF);
    endtask

    task automatic reset_line_engine();
        eng_phase      = PH_IDLE;
        eng_bits       = '0;
        eng_shift      = '0;
        eng_hold       = '0;
        eng_polls      = '0;
        eng_scl        = 1'b1;
        eng_sda        = 1'b1;
        eng_drv        = 1'b1;
        eng_ack_choice = 1'b0;
        eng_rx         = '0;
        eng_miss       = 1'b0;
        eng_timeout    = ACK_TIMEOUT_RST;
    endtask

    task automatic step_line_engine(input t_tick t, output t_result r);
        logic fin;
        fin = 1'b0;
        if (eng_phase == PH_IDLE) begin
            if (t.cmd_valid) begin
                case (t.opcode)
                    OP_START: begin
                        eng_drv = 1'b1; eng_sda = 1'b1; eng_scl = 1'b1;
                        enter_phase(PH_ST_A, EDGE_HOLD_TICKS_DEF);
                    end
                    OP_STOP: begin
                        eng_drv = 1'b1; eng_scl = 1'b0; eng_sda = 1'b0;
                        enter_phase(PH_SP_A, EDGE_HOLD_TICKS_DEF);
                    end
                    OP_WRITE: begin
                        eng_drv = 1'b1; eng_scl = 1'b0;
                        eng_shift = t.write_byte;
                        eng_bits  = '0;
                        load_write_bit();
                    end
                    OP_READ: begin
                        eng_drv = 1'b0; eng_scl = 1'b0;
                        eng_ack_choice = t.send_ack;
                        eng_shift = '0;
                        eng_bits  = '0;
                        enter_phase(PH_R_LOW, BIT_PHASE_TICKS_DEF);
                    end
                    OP_WACK: begin
                        eng_drv = 1'b0; eng_sda = 1'b1;
                        enter_phase(PH_A_REL, 1);
                    end
                    default: ;
                endcase
            end
        end else if (eng_phase == PH_A_POLL) begin
            poll_ack(t.sda_sample, fin);
        end else if (eng_hold != 0) begin
            eng_hold = eng_hold - 4'd1;
        end else begin
            case (eng_phase)
                PH_ST_A: begin
                    eng_sda = 1'b0;
                    enter_phase(PH_ST_B, EDGE_HOLD_TICKS_DEF);
                end
                PH_ST_B: begin
                    eng_scl = 1'b0; eng_phase = PH_IDLE; fin = 1'b1;
                end
                PH_SP_A: begin
                    eng_scl = 1'b1; eng_sda = 1'b1;
                    enter_phase(PH_SP_B, EDGE_HOLD_TICKS_DEF);
                end
                PH_SP_B: begin
                    eng_phase = PH_IDLE; fin = 1'b1;
                end
                PH_W_DATA: begin
                    eng_scl = 1'b1;
                    enter_phase(PH_W_HIGH, BIT_PHASE_TICKS_DEF);
                end
                PH_W_HIGH: begin
                    eng_scl = 1'b0;
                    enter_phase(PH_W_LOW, BIT_PHASE_TICKS_DEF);
                end
                PH_W_LOW: begin
                    eng_bits = eng_bits + 4'd1;
                    if (eng_bits >= BITS_PER_BYTE) begin
                        eng_phase = PH_IDLE; fin = 1'b1;
                    end else begin
                        load_write_bit();
                    end
                end
                PH_R_LOW: begin
                    // data bit taken on the rising scl tick
                    eng_scl   = 1'b1;
                    eng_shift = {eng_shift[6:0], t.sda_sample};
                    eng_bits  = eng_bits + 4'd1;
                    enter_phase(PH_R_HIGH, 1);
                end
                PH_R_HIGH: begin
                    eng_scl = 1'b0;
                    if (eng_bits >= BITS_PER_BYTE) begin
                        eng_rx  = eng_shift;
                        eng_drv = 1'b1;
                        eng_sda = !eng_ack_choice;
                        enter_phase(PH_K_LOW, BIT_PHASE_TICKS_DEF);
                    end else begin
                        enter_phase(PH_R_LOW, BIT_PHASE_TICKS_DEF);
                    end
                end
                PH_K_LOW: begin
                    eng_scl = 1'b1;
                    enter_phase(PH_K_HIGH, BIT_PHASE_TICKS_DEF);
                end
                PH_K_HIGH: begin
                    eng_scl = 1'b0; eng_phase = PH_IDLE; fin = 1'b1;
                end
                PH_A_REL: begin
                    eng_scl = 1'b1;
                    enter_phase(PH_A_RISE, 1);
                end
                PH_A_RISE: begin
                    eng_phase = PH_A_POLL;
                    eng_polls = '0;
                    poll_ack(t.sda_sample, fin);
                end
                default: eng_phase = PH_IDLE;
            endcase
        end
        r.scl_level   = eng_scl;
        r.sda_level   = eng_sda;
        r.sda_drive   = eng_drv;
        r.busy_res    = (eng_phase != PH_IDLE);
        r.done_res    = fin;
        r.read_data   = eng_rx;
        r.ack_missing = eng_miss;
    endtask

    // sda level the slave side shows on the next tick
    task automatic next_sda(output logic s);
        if (eng_phase inside {PH_A_RISE, PH_A_POLL}) begin
            s = (ack_highs_left != 0);
            if (s)
                ack_highs_left = ack_highs_left - 1;
        end else if (eng_phase == PH_R_LOW && !read_rand) begin
            s = read_fill;
        end else begin
            s = 1'($urandom_range(0, 1));
        end
    endtask

    function automatic t_tick make_tick(input logic cmd, input logic [OPCODE_W-1:0] op,
                                        input logic [7:0] wb, input logic sack,
                                        input logic sda);
        t_tick t;
        t.cmd_valid  = cmd;
        t.opcode     = op;
        t.write_byte = wb;
        t.send_ack   = sack;
        t.sda_sample = sda;
        return t;
    endfunction

    // while busy the command fields are noise the engine must ignore
    task automatic make_busy_tick(output t_tick t);
        logic s;
        next_sda(s);
        t = make_tick($urandom_range(0, 3) == 0, 3'($urandom_range(0, 7)),
                      8'($urandom), 1'($urandom_range(0, 1)), s);
    endtask

    task automatic send_tick(input t_tick t, input logic typed, input t_result want);
        t_result r;
        if ($urandom_range(0, 99) == 0)
            tx_burst = !tx_burst;
        if (!tx_burst && $urandom_range(0, 99) < 30) begin
            s_axis_tvalid <= 1'b0;
            repeat (pick_gap()) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'b0, t.sda_sample, t.send_ack, t.write_byte};
        s_axis_tuser  <= {t.opcode, t.cmd_valid};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        step_line_engine(t, r);
        bus_levels_q.push_back(typed ? want : r);
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (bus_levels_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_ack_timeout(input logic [7:0] v);
        drain_results();
        repeat (4) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        eng_timeout = v;
    endtask

    task automatic add_row(input logic cmd, input logic [OPCODE_W-1:0] op,
                           input logic [7:0] wb, input logic sack, input logic fill,
                           input int unsigned highs, input logic typed, input t_result want);
        t_cmd_row row;
        row.cmd       = cmd;
        row.op        = op;
        row.wbyte     = wb;
        row.sack      = sack;
        row.sda_fill  = fill;
        row.ack_highs = 9'(highs);
        row.typed     = typed;
        row.want      = want;
        cmd_table.push_back(row);
    endtask

    task automatic pick_command(output t_tick t);
        int unsigned r;
        int unsigned w;
        logic [OPCODE_W-1:0] op;
        logic [7:0] wb;
        logic s;
        r = $urandom_range(0, 99);
        w = $urandom_range(0, 99);
        if (w < 15)      op = OP_START;
        else if (w < 30) op = OP_STOP;
        else if (w < 55) op = OP_WRITE;
        else if (w < 75) op = OP_READ;
        else             op = OP_WACK;
        if (r >= 8 && r < 14)
            op = 3'($urandom_range(OP_RSVD5, OP_RSVD7));
        w = $urandom_range(0, 9);
        wb = (w == 0) ? 8'h00 : (w == 1) ? 8'hFF : 8'($urandom);
        read_rand = 1'b1;
        if (r >= 14 && op == OP_WACK) begin
            w = $urandom_range(0, 99);
            if (force_timeout || (w < 15 && eng_timeout < 32))
                ack_highs_left = ACK_NEVER;
            else if (w < 75)
                ack_highs_left = $urandom_range(0, 3);
            else
                ack_highs_left = $urandom_range(0, int'(eng_timeout) + 1);
            force_timeout = 1'b0;
        end
        next_sda(s);
        t = make_tick(r >= 8, op, wb, 1'($urandom_range(0, 1)), s);
    endtask

    initial begin
        t_tick       t;
        t_cmd_row    row;
        int unsigned n;
        logic [7:0]  timeouts [4];

        reset_line_engine();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        add_row(1'b0, OP_START, 8'h5A, 1'b1, 1'b1, 0, 1'b1, IDLE_LINES);
        add_row(1'b1, OP_RSVD5, 8'hFF, 1'b1, 1'b1, 0, 1'b1, IDLE_LINES);
        add_row(1'b1, OP_RSVD6, 8'h00, 1'b0, 1'b0, 0, 1'b1, IDLE_LINES);
        add_row(1'b1, OP_RSVD7, 8'hA5, 1'b1, 1'b0, 0, 1'b1, IDLE_LINES);
        add_row(1'b1, OP_START, 8'h00, 1'b0, 1'b1, 0, 1'b1, START_LINES);
        add_row(1'b1, OP_WRITE, 8'h00, 1'b0, 1'b1, 0, 1'b0, '0);
        add_row(1'b1, OP_WRITE, 8'hFF, 1'b1, 1'b0, 0, 1'b0, '0);
        add_row(1'b1, OP_WRITE, 8'hA5, 1'b0, 1'b1, 0, 1'b0, '0);
        add_row(1'b1, OP_WACK,  8'h00, 1'b0, 1'b1, 0, 1'b0, '0);
        add_row(1'b1, OP_WACK,  8'h00, 1'b0, 1'b1, 5, 1'b0, '0);
        add_row(1'b1, OP_READ,  8'h00, 1'b1, 1'b1, 0, 1'b0, '0);
        add_row(1'b1, OP_READ,  8'hFF, 1'b0, 1'b0, 0, 1'b0, '0);
        add_row(1'b1, OP_WACK,  8'h00, 1'b0, 1'b1, ACK_NEVER, 1'b0, '0);
        add_row(1'b1, OP_WACK,  8'h00, 1'b1, 1'b1, 2, 1'b0, '0);
        add_row(1'b1, OP_STOP,  8'h00, 1'b0, 1'b1, 0, 1'b0, '0);

        foreach (cmd_table[i]) begin
            row = cmd_table[i];
            ack_highs_left = row.ack_highs;
            read_rand      = 1'b0;
            read_fill      = row.sda_fill;
            t = make_tick(row.cmd, row.op, row.wbyte, row.sack, 1'($urandom_range(0, 1)));
            send_tick(t, row.typed, row.want);
            while (eng_phase != PH_IDLE) begin
                make_busy_tick(t);
                send_tick(t, 1'b0, '0);
            end
        end

        timeouts[0] = 8'd0;
        timeouts[1] = 8'd255;
        timeouts[2] = 8'($urandom_range(2, 254));
        timeouts[3] = 8'd1;
        foreach (timeouts[p]) begin
            write_ack_timeout(timeouts[p]);
            force_timeout = 1'b1;
            n = 0;
            while (n < PHASE_TICKS || eng_phase != PH_IDLE) begin
                if (eng_phase == PH_IDLE)
                    pick_command(t);
                else
                    make_busy_tick(t);
                send_tick(t, 1'b0, '0);
                n++;
                if ($urandom_range(0, 99) == 0)
                    drain_results();
            end
        end

        drain_results();
        repeat (8) @(posedge i_clk);
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // result side back-pressure
    always @(posedge i_clk) begin
        if ($urandom_range(0, 199) == 0)
            rx_burst <= !rx_burst;
        if (rx_stall_left != 0) begin
            m_axis_tready <= 1'b0;
            rx_stall_left <= rx_stall_left - 1;
        end else if (!rx_burst && $urandom_range(0, 99) < 25) begin
            m_axis_tready <= 1'b0;
            rx_stall_left <= pick_gap() - 1;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin : result_check
        t_result got;
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = t_result'(m_axis_tdata[13:0]);
            if (bus_levels_q.size() == 0) begin
                $error("result transaction 0x%0h with nothing expected", m_axis_tdata);
                fail_count++;
            end else begin
                want = bus_levels_q.pop_front();
                check_field("scl_level", want.scl_level, got.scl_level);
                check_field("sda_level", want.sda_level, got.sda_level);
                check_field("sda_drive", want.sda_drive, got.sda_drive);
                check_field("busy_res", want.busy_res, got.busy_res);
                check_field("done_res", want.done_res, got.done_res);
                check_field("read_data", want.read_data, got.read_data);
                check_field("ack_missing", want.ack_missing, got.ack_missing);
                check_field("tdata pad", 0, m_axis_tdata[15:14]);
            end
        end
    end

    // stall watchdog
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule
